// ===== design/tmml_pkg.sv =====
// Package for the table motor mixer/limiter: widths, register codes, constants,
// term tag type and sequencer state type. No dependencies.
`timescale 1ns / 1ps

package tmml_pkg;

    // Default motor count, top level parameter default
    localparam int NUM_MOTORS_DEF = 12;

    // Mixer factor table
    localparam int TABLE_WORDS = 24;
    localparam int TBL_IDX_W   = 5;
    localparam int WORD_W      = 16;

    // Field widths
    localparam int MOTOR_IDX_W = 4;
    localparam int GAS_W       = 8;
    localparam int CHAN_W      = 12;
    localparam int CORR_W      = 16;
    localparam int FACT_W      = 8;

    // Stream payload widths
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 8;

    // Configuration register codes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAS = 1'd1;

    localparam logic [GAS_W-1:0] MIN_GAS_RST = 8'd10;
    localparam logic [GAS_W-1:0] MAX_GAS_RST = 8'd200;

    // Input item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MIX  = 1'b1;

    // Throttle scaling: (ch - 1000) / (1000 / max_gas)
    localparam int DIV_NUM_W = 12;
    localparam int DIV_DEN_W = 10;
    localparam logic [DIV_NUM_W-1:0] CH_OFFSET = 12'd1000;
    localparam logic [DIV_NUM_W-1:0] SCALE_NUM = 12'd1000;

    // Divide by 100: q = (x * ceil(2^30 / 100)) >> 30, exact for x < 2^23
    localparam int PROD_W      = 23;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    // Term selector within one motor
    localparam logic [1:0] TERM_THR  = 2'd0;
    localparam logic [1:0] TERM_ROLL = 2'd1;
    localparam logic [1:0] TERM_NICK = 2'd2;
    localparam logic [1:0] TERM_YAW  = 2'd3;

    // Tag that follows a term through the multiplier pipeline
    typedef struct packed {
        logic [MOTOR_IDX_W-1:0] motor;
        logic                   motor_end;
    } term_tag_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DIV_SCALE = 6'b000010,
        S_DIV_THR   = 6'b000100,
        S_MIX       = 6'b001000,
        S_DRAIN     = 6'b010000,
        S_OUT       = 6'b100000
    } seq_state_t;

endpackage

// ===== design/table_motor_mixer_limiter_core.sv =====
// Mix item: two throttle divider passes, then one term a cycle (4*NUM_MOTORS terms)
// into the shared multiplier, a drain of the term unit, then one result a cycle
// while m_tready allows it; input ready returns once the last result is registered.
// Load item and configuration write: taken without a stall, no result. Reset (rst_n, async
// low): table cleared, min_gas 10, max_gas 200, idle. Uses tmml_pkg, tmml_div, tmml_term.
`timescale 1ns / 1ps

module table_motor_mixer_limiter_core
    import tmml_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAS_W-1:0]     cfg_data,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [4:0] word_index, [20:5] word_data, [32:21] throttle_channel,
    // [48:33] roll_correction, [64:49] nick_correction, [80:65] yaw_correction
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] cmd
    input  logic                 s_tuser,
    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] motor_value
    output logic [M_TDATA_W-1:0] m_tdata,
    // [3:0] motor_index
    output logic [MOTOR_IDX_W-1:0] m_tuser,
    output logic                 m_tlast
);

    localparam int MOT_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic [MOT_W-1:0] MOT_LAST = MOT_W'(NUM_MOTORS - 1);

    seq_state_t state_reg, state_next;

    logic [GAS_W-1:0]  min_gas_reg, max_gas_reg;
    logic [WORD_W-1:0] table_reg [TABLE_WORDS];

    logic [CHAN_W-1:0]        chan_reg, chan_next;
    logic signed [CORR_W-1:0] roll_reg, roll_next;
    logic signed [CORR_W-1:0] nick_reg, nick_next;
    logic signed [CORR_W-1:0] yaw_reg, yaw_next;
    logic [GAS_W-1:0]         thr_reg, thr_next;

    logic [MOT_W-1:0]         iss_m_reg, iss_m_next;
    logic [1:0]               iss_j_reg, iss_j_next;
    logic [WORD_W-1:0]        acc_reg, acc_next;
    logic signed [16:0]       mn_reg, mn_next;
    logic signed [16:0]       mx_reg, mx_next;
    logic signed [WORD_W-1:0] raw_reg [NUM_MOTORS];
    logic [MOT_W-1:0]         out_cnt_reg, out_cnt_next;

    logic                   m_valid_reg, m_valid_next;
    logic [GAS_W-1:0]       m_val_reg, m_val_next;
    logic [MOTOR_IDX_W-1:0] m_idx_reg, m_idx_next;
    logic                   m_last_reg, m_last_next;

    logic s_xfer;
    logic raw_we;

    // Divider hookup
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic                 div_busy;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    // Term unit hookup
    logic                     term_valid;
    logic signed [CORR_W-1:0] term_a;
    logic signed [FACT_W-1:0] term_f;
    term_tag_t                term_tag;
    logic                     q_valid;
    logic [WORD_W-1:0]        q_val;
    term_tag_t                q_tag;
    logic [WORD_W-1:0]        sum;
    logic signed [16:0]       sum_x;
    logic [WORD_W-1:0]        fact_word;

    // Limiter
    logic signed [18:0] lv, lmx, lmn, lgmax, lgmin, lres;

    assign s_xfer    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    tmml_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Operand and factor selection for the term being issued
    always_comb
    begin
        fact_word = table_reg[TBL_IDX_W'({iss_m_reg, iss_j_reg[1]})];
        term_f    = iss_j_reg[0] ? fact_word[FACT_W-1:0] : fact_word[WORD_W-1:FACT_W];
        unique case (iss_j_reg)
            TERM_THR:  term_a = $signed({{(CORR_W-GAS_W){1'b0}}, thr_reg});
            TERM_ROLL: term_a = roll_reg;
            TERM_NICK: term_a = nick_reg;
            TERM_YAW:  term_a = yaw_reg;
            default:   term_a = roll_reg;
        endcase
        term_tag.motor     = MOTOR_IDX_W'(iss_m_reg);
        term_tag.motor_end = (iss_j_reg == TERM_YAW);
    end

    tmml_term u_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (term_valid),
        .operand   (term_a),
        .factor    (term_f),
        .in_tag    (term_tag),
        .out_valid (q_valid),
        .out_q     (q_val),
        .out_tag   (q_tag)
    );

    assign sum   = acc_reg + q_val;
    assign sum_x = $signed({sum[WORD_W-1], sum});

    // Shift and clamp of the motor at the output counter
    always_comb
    begin
        lv    = 19'(raw_reg[out_cnt_reg]);
        lmx   = 19'(mx_reg);
        lmn   = 19'(mn_reg);
        lgmax = $signed({11'd0, max_gas_reg});
        lgmin = $signed({11'd0, min_gas_reg});
        priority if (lmx > lgmax)
        begin
            lres = lv - lmx + lgmax;
            if (lres < lgmin)
                lres = lgmin;
        end
        else if (lmn < lgmin)
        begin
            lres = lv + lgmin - lmn;
            if (lres > lgmax)
                lres = lgmax;
        end
        else
        begin
            lres = lv;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        roll_next    = roll_reg;
        nick_next    = nick_reg;
        yaw_next     = yaw_reg;
        thr_next     = thr_reg;
        iss_m_next   = iss_m_reg;
        iss_j_next   = iss_j_reg;
        acc_next     = acc_reg;
        mn_next      = mn_reg;
        mx_next      = mx_reg;
        out_cnt_next = out_cnt_reg;
        m_valid_next = m_valid_reg;
        m_val_next   = m_val_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        term_valid   = 1'b0;
        raw_we       = 1'b0;

        // output register emptied by a transfer
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_xfer && (s_tuser == CMD_MIX))
                begin
                    chan_next    = s_tdata[32:21];
                    roll_next    = s_tdata[48:33];
                    nick_next    = s_tdata[64:49];
                    yaw_next     = s_tdata[80:65];
                    div_start    = 1'b1;
                    div_dividend = SCALE_NUM;
                    div_divisor  = (max_gas_reg == '0) ? DIV_DEN_W'(1)
                                                       : DIV_DEN_W'(max_gas_reg);
                    state_next   = S_DIV_SCALE;
                end
            end
            S_DIV_SCALE:
            begin
                // throttle divisor ready, start the throttle division
                if (div_done && !div_busy)
                begin
                    div_start    = 1'b1;
                    div_dividend = (chan_reg < CH_OFFSET) ? '0 : (chan_reg - CH_OFFSET);
                    div_divisor  = div_quot[DIV_DEN_W-1:0];
                    state_next   = S_DIV_THR;
                end
            end
            S_DIV_THR:
            begin
                if (div_done)
                begin
                    thr_next   = div_quot[GAS_W-1:0];
                    iss_m_next = '0;
                    iss_j_next = TERM_THR;
                    acc_next   = '0;
                    mn_next    = $signed({9'd0, min_gas_reg});
                    mx_next    = $signed({9'd0, max_gas_reg});
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                // one term per cycle into the shared unit
                term_valid = 1'b1;
                iss_j_next = iss_j_reg + 1'b1;
                if (iss_j_reg == TERM_YAW)
                begin
                    if (iss_m_reg == MOT_LAST)
                        state_next = S_DRAIN;
                    else
                        iss_m_next = iss_m_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DRAIN;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_val_next   = lres[GAS_W-1:0];
                    m_idx_next   = MOTOR_IDX_W'(out_cnt_reg);
                    m_last_next  = (out_cnt_reg == MOT_LAST);
                    out_cnt_next = out_cnt_reg + 1'b1;
                    if (out_cnt_reg == MOT_LAST)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Accumulate quotients; close a motor on its yaw term
        if (q_valid)
        begin
            if (q_tag.motor_end)
            begin
                acc_next = '0;
                raw_we   = 1'b1;
                if (sum_x < mn_next)
                    mn_next = sum_x;
                if (sum_x > mx_next)
                    mx_next = sum_x;
                if (q_tag.motor[MOT_W-1:0] == MOT_LAST)
                begin
                    state_next   = S_OUT;
                    out_cnt_next = '0;
                end
            end
            else
            begin
                acc_next = sum;
            end
        end
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            min_gas_reg <= MIN_GAS_RST;
            max_gas_reg <= MAX_GAS_RST;
            iss_m_reg   <= '0;
            iss_j_reg   <= TERM_THR;
            out_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            iss_m_reg   <= iss_m_next;
            iss_j_reg   <= iss_j_next;
            out_cnt_reg <= out_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MIN_GAS: min_gas_reg <= cfg_data;
                    REG_MAX_GAS: max_gas_reg <= cfg_data;
                    default:     min_gas_reg <= min_gas_reg;
                endcase
            end
        end
    end

    // Factor table, cleared at reset, written by load items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_WORDS; i++)
                table_reg[i] <= '0;
        end
        else if (s_xfer && (s_tuser == CMD_LOAD) &&
                 (s_tdata[TBL_IDX_W-1:0] < TBL_IDX_W'(TABLE_WORDS)))
        begin
            table_reg[s_tdata[TBL_IDX_W-1:0]] <= s_tdata[20:5];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chan_reg   <= chan_next;
        roll_reg   <= roll_next;
        nick_reg   <= nick_next;
        yaw_reg    <= yaw_next;
        thr_reg    <= thr_next;
        acc_reg    <= acc_next;
        mn_reg     <= mn_next;
        mx_reg     <= mx_next;
        m_val_reg  <= m_val_next;
        m_idx_reg  <= m_idx_next;
        m_last_reg <= m_last_next;
        if (raw_we)
            raw_reg[q_tag.motor[MOT_W-1:0]] <= $signed(sum);
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_val_reg;
    assign m_tuser  = m_idx_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/tmml_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tmml_pkg for operand widths.
`timescale 1ns / 1ps

module tmml_div
    import tmml_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 busy,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_NUM_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 q_bit;

    // One restoring step
    always_comb
    begin
        shifted = {rem_reg, num_reg[DIV_NUM_W-1]};
        diff    = shifted - {1'b0, den_reg};
        q_bit   = (shifted >= {1'b0, den_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (busy_reg)
        begin
            num_next = {num_reg[DIV_NUM_W-2:0], q_bit};
            rem_next = q_bit ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand registers, no reset
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== design/tmml_term.sv =====
// Shared term unit: signed product of an operand and a factor, divided by 100
// toward zero via a reciprocal multiply. Two register stages. Uses tmml_pkg.
`timescale 1ns / 1ps

module tmml_term
    import tmml_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [CORR_W-1:0] operand,
    input  logic signed [FACT_W-1:0] factor,
    input  term_tag_t                in_tag,
    output logic                     out_valid,
    output logic [WORD_W-1:0]        out_q,
    output term_tag_t                out_tag
);

    localparam int WIDE_W = PROD_W + RECIP_W;

    logic [CORR_W-1:0] mag_a;
    logic [FACT_W-1:0] mag_f;
    logic [PROD_W-1:0] prod;
    logic [WIDE_W-1:0] wide;

    logic              v1_reg, v2_reg;
    logic [PROD_W-1:0] p1_reg;
    logic              neg1_reg, neg2_reg;
    term_tag_t         tag1_reg, tag2_reg;
    logic [WORD_W-1:0] q2_reg;

    // Stage 1: magnitudes and their product
    always_comb
    begin
        mag_a = operand[CORR_W-1] ? (~operand + 1'b1) : operand;
        mag_f = factor[FACT_W-1] ? (~factor + 1'b1) : factor;
        prod  = {{(PROD_W-CORR_W){1'b0}}, mag_a} * {{(PROD_W-FACT_W){1'b0}}, mag_f};
    end

    // Stage 2: reciprocal multiply for the divide by 100
    assign wide = WIDE_W'(p1_reg) * WIDE_W'(RECIP_100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= prod;
        neg1_reg <= operand[CORR_W-1] ^ factor[FACT_W-1];
        tag1_reg <= in_tag;
        q2_reg   <= wide[RECIP_SHIFT +: WORD_W];
        neg2_reg <= neg1_reg;
        tag2_reg <= tag1_reg;
    end

    // Sign restore, wrapped to 16 bits
    assign out_q     = neg2_reg ? (~q2_reg + 1'b1) : q2_reg;
    assign out_valid = v2_reg;
    assign out_tag   = tag2_reg;

endmodule

// ===== design/tmml_checker.sv =====
// Port-level checker for table_motor_mixer_limiter_core, bound to the top.
// Depends on tmml_pkg.
`timescale 1ns / 1ps

module tmml_checker
    import tmml_pkg::*;
#(
    parameter int NUM_MOTORS = NUM_MOTORS_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_TDATA_W-1:0]   m_tdata,
    input logic [MOTOR_IDX_W-1:0] m_tuser,
    input logic                   m_tlast
);

    localparam logic [MOTOR_IDX_W-1:0] IDX_LAST = MOTOR_IDX_W'(NUM_MOTORS - 1);

    // A mix transfer occupies the block
    a_mix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_MIX)) |=> !s_tready)
        else $error("input ready right after a mix transfer");

    // A load transfer never stalls the input
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == CMD_LOAD)) |=> s_tready)
        else $error("input stalled after a load transfer");

    // Last flag marks exactly the final motor
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == IDX_LAST)))
        else $error("last flag and motor index disagree");

    // Held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind table_motor_mixer_limiter_core tmml_checker #(.NUM_MOTORS(NUM_MOTORS)) u_tmml_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
